>>> rtl/tea_pkg.sv
package tea_pkg;

  // fixed field widths
  localparam int ID_W   = 10;
  localparam int VERT_W = 16;
  localparam int CNT_W  = 11;
  localparam int SLOT_W = 2;
  localparam int ENT_W  = 3 * VERT_W;

  // register port
  localparam int DATA_W = 32;
  localparam int ADDR_W = 3;

  // parameter defaults
  localparam int MAX_TRIS_DEF = 1024;
  localparam int MAX_NB_DEF   = 8;

  // opcodes of an input word
  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // register indexes
  localparam logic [ADDR_W-3:0] REG_TRI_COUNT = '0;

  typedef enum logic [2:0] {
    S_IDLE,
    S_QFETCH,
    S_SCAN,
    S_SUM,
    S_DRAIN
  } tea_state_t;

  // commands from controller to datapath
  typedef struct packed {
    logic load_wr;
    logic q_start;
    logic q_fetch;
    logic scan_step;
    logic sum;
    logic emit;
  } tea_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic id_ok;
    logic cnt_zero;
    logic scan_last;
    logic out_free;
    logic drain_last;
  } tea_stat_t;

  // next vertex position around a triangle
  function automatic int nxt3(input int k);
    return (k == 2) ? 0 : k + 1;
  endfunction

endpackage

>>> rtl/tea_ctrl.sv
module tea_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_op,
  input  tea_pkg::tea_stat_t stat,
  output logic              in_stall,
  output tea_pkg::tea_cmd_t  cmd
);
  import tea_pkg::*;

  tea_state_t state_r, state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid && in_op == OP_QUERY) state_nxt = S_QFETCH;
      end
      S_QFETCH: begin
        if (!stat.id_ok || stat.cnt_zero) state_nxt = S_SUM;
        else state_nxt = S_SCAN;
      end
      S_SCAN: begin
        if (stat.scan_last) state_nxt = S_SUM;
      end
      S_SUM: begin
        state_nxt = S_DRAIN;
      end
      S_DRAIN: begin
        if (stat.out_free && stat.drain_last) state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // command outputs
  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    case (state_r)
      S_IDLE: begin
        in_stall    = 1'b0;
        cmd.load_wr = in_valid && in_op == OP_LOAD;
        cmd.q_start = in_valid && in_op == OP_QUERY;
      end
      S_QFETCH: begin
        cmd.q_fetch = 1'b1;
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
      end
      S_SUM: begin
        cmd.sum = 1'b1;
      end
      S_DRAIN: begin
        cmd.emit = stat.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

>>> rtl/tea_dp.sv
module tea_dp #(
  parameter int MAX_TRIS       = tea_pkg::MAX_TRIS_DEF,
  parameter int MAX_NEIGHBOURS = tea_pkg::MAX_NB_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  tea_pkg::tea_cmd_t           cmd,
  output tea_pkg::tea_stat_t          stat,
  input  logic [tea_pkg::CNT_W-1:0]   tri_count,
  input  logic [tea_pkg::ID_W-1:0]    in_tri_id,
  input  logic [tea_pkg::VERT_W-1:0]  in_vert_a,
  input  logic [tea_pkg::VERT_W-1:0]  in_vert_b,
  input  logic [tea_pkg::VERT_W-1:0]  in_vert_c,
  input  logic                        out_stall,
  output logic                        out_valid,
  output logic [tea_pkg::ID_W-1:0]    out_neighbour_id,
  output logic [tea_pkg::SLOT_W-1:0]  out_edge_slot,
  output logic                        out_found,
  output logic                        out_overflow,
  output logic                        out_last
);
  import tea_pkg::*;

  localparam int AW = (MAX_TRIS > 1) ? $clog2(MAX_TRIS) : 1;
  localparam int NW = $clog2(MAX_NEIGHBOURS);
  localparam int CW = $clog2(MAX_NEIGHBOURS + 2);
  localparam int SW = $clog2(3 * MAX_NEIGHBOURS + 4) + 1;

  // vertex table
  logic [ENT_W-1:0] mem [MAX_TRIS];
  logic [ENT_W-1:0] rd_data_r;
  logic [AW-1:0]    rd_addr;
  logic             in_id_ok;

  // query and scan state
  logic [ID_W-1:0]  qid_r;
  logic [ENT_W-1:0] qv_r;
  logic [CNT_W-1:0] scan_r;
  logic [CNT_W-1:0] scan_nx;

  // per-edge match lists
  logic [ID_W-1:0]  nb_r [3][MAX_NEIGHBOURS];
  logic [CW-1:0]    cnt_r [3];
  logic [2:0]       hit [3];
  logic [SW-1:0]    fill [3];

  // drain bookkeeping
  logic [SW-1:0]     c0m_r, c01_r, ntot_r, o_r;
  logic              over_r;
  logic [CW-1:0]     cm [3];
  logic [SW-1:0]     tot, raw;
  logic [SLOT_W-1:0] es;
  logic [NW-1:0]     ei;
  logic              d_last;

  // output register
  logic              out_valid_r;
  logic [ID_W-1:0]   out_id_r;
  logic [SLOT_W-1:0] out_slot_r;
  logic              out_found_r, out_over_r, out_last_r;

  assign in_id_ok = 32'(in_tri_id) < 32'(MAX_TRIS);
  assign scan_nx  = scan_r + CNT_W'(1);

  // read address select: request slot, first entry, next scan entry
  always_comb begin
    if (cmd.scan_step) rd_addr = AW'(scan_nx);
    else if (cmd.q_fetch) rd_addr = '0;
    else rd_addr = AW'(in_tri_id);
  end

  // table write and registered read
  always_ff @(posedge clk) begin
    if (cmd.load_wr && in_id_ok) begin
      mem[AW'(in_tri_id)] <= {in_vert_c, in_vert_b, in_vert_a};
    end
    rd_data_r <= mem[rd_addr];
  end

  // query capture and scan counter
  always_ff @(posedge clk) begin
    if (cmd.q_start) qid_r <= in_tri_id;
    if (cmd.q_fetch) begin
      qv_r   <= rd_data_r;
      scan_r <= '0;
    end else if (cmd.scan_step) begin
      scan_r <= scan_nx;
    end
  end

  // reversed edge compare of the scanned entry against each query edge
  always_comb begin
    for (int s = 0; s < 3; s++) begin
      for (int t = 0; t < 3; t++) begin
        hit[s][t] = (rd_data_r[t*VERT_W +: VERT_W] == qv_r[nxt3(s)*VERT_W +: VERT_W]) &&
                    (rd_data_r[nxt3(t)*VERT_W +: VERT_W] == qv_r[s*VERT_W +: VERT_W]);
      end
      fill[s] = SW'(cnt_r[s]) + SW'(hit[s][0]) + SW'(hit[s][1]) + SW'(hit[s][2]);
    end
  end

  // match counts, saturating one above the list depth
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.q_start) begin
      for (int s = 0; s < 3; s++) cnt_r[s] <= '0;
    end else if (cmd.scan_step) begin
      for (int s = 0; s < 3; s++) begin
        if (fill[s] > SW'(MAX_NEIGHBOURS + 1)) cnt_r[s] <= CW'(MAX_NEIGHBOURS + 1);
        else cnt_r[s] <= CW'(fill[s]);
      end
    end
  end

  // list write, one copy of the id per matching edge position
  always_ff @(posedge clk) begin
    if (cmd.scan_step) begin
      for (int s = 0; s < 3; s++) begin
        for (int i = 0; i < MAX_NEIGHBOURS; i++) begin
          if (SW'(i) >= SW'(cnt_r[s]) && SW'(i) < fill[s]) begin
            nb_r[s][i] <= scan_r[ID_W-1:0];
          end
        end
      end
    end
  end

  // clipped totals for the drain
  always_comb begin
    for (int s = 0; s < 3; s++) begin
      cm[s] = (32'(cnt_r[s]) > 32'(MAX_NEIGHBOURS)) ? CW'(MAX_NEIGHBOURS) : cnt_r[s];
    end
    tot = SW'(cm[0]) + SW'(cm[1]) + SW'(cm[2]);
    raw = SW'(cnt_r[0]) + SW'(cnt_r[1]) + SW'(cnt_r[2]);
  end

  always_ff @(posedge clk) begin
    if (cmd.sum) begin
      c0m_r  <= SW'(cm[0]);
      c01_r  <= SW'(cm[0]) + SW'(cm[1]);
      ntot_r <= (tot > SW'(MAX_NEIGHBOURS)) ? SW'(MAX_NEIGHBOURS) : tot;
      over_r <= raw > SW'(MAX_NEIGHBOURS);
    end
  end

  // map the running result number to an edge list and a place in it
  always_comb begin
    if (o_r < c0m_r) begin
      es = SLOT_W'(0);
      ei = NW'(o_r);
    end else if (o_r < c01_r) begin
      es = SLOT_W'(1);
      ei = NW'(o_r - c0m_r);
    end else begin
      es = SLOT_W'(2);
      ei = NW'(o_r - c01_r);
    end
    d_last = (o_r + SW'(1)) >= ntot_r;
  end

  // result counter
  always_ff @(posedge clk) begin
    if (cmd.sum) o_r <= '0;
    else if (cmd.emit) o_r <= o_r + SW'(1);
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_found_r <= ntot_r != '0;
      out_id_r    <= (ntot_r != '0) ? nb_r[es][ei] : '0;
      out_slot_r  <= (ntot_r != '0) ? es : '0;
      out_over_r  <= d_last && over_r;
      out_last_r  <= d_last;
    end
  end

  // status
  always_comb begin
    stat.id_ok      = 32'(qid_r) < 32'(MAX_TRIS);
    stat.cnt_zero   = tri_count == '0;
    stat.scan_last  = (scan_nx == tri_count) || (32'(scan_nx) == 32'(MAX_TRIS));
    stat.out_free   = !out_valid_r || !out_stall;
    stat.drain_last = d_last;
  end

  assign out_valid        = out_valid_r;
  assign out_neighbour_id = out_id_r;
  assign out_edge_slot    = out_slot_r;
  assign out_found        = out_found_r;
  assign out_overflow     = out_over_r;
  assign out_last         = out_last_r;

endmodule

>>> rtl/triangle_edge_adjacency_top.sv
// channel   direction  handshake           payload
// in        input      in_valid/in_stall   op, tri_id, vert_a, vert_b, vert_c
// out       output     out_valid/out_stall neighbour_id, edge_slot, found, overflow, last
// config    input      psel/penable/pready paddr, pwdata, prdata (triangle_count at 0x0)
//
// a load writes in idle; a query fetches, scans N = min(triangle_count, MAX_TRIS) entries
// at one table read per cycle, sums, sends R results at one per cycle while output is free
// one query at a time; input is held off from query accept until its last result is loaded
// the result register lets the next word in while the final result waits on out_stall
// reset is synchronous, active low; the vertex table holds no reset and is never cleared
module triangle_edge_adjacency_top #(
  parameter int MAX_TRIS       = tea_pkg::MAX_TRIS_DEF,
  parameter int MAX_NEIGHBOURS = tea_pkg::MAX_NB_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         in_op,
  input  logic [tea_pkg::ID_W-1:0]     in_tri_id,
  input  logic [tea_pkg::VERT_W-1:0]   in_vert_a,
  input  logic [tea_pkg::VERT_W-1:0]   in_vert_b,
  input  logic [tea_pkg::VERT_W-1:0]   in_vert_c,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [tea_pkg::ID_W-1:0]     out_neighbour_id,
  output logic [tea_pkg::SLOT_W-1:0]   out_edge_slot,
  output logic                         out_found,
  output logic                         out_overflow,
  output logic                         out_last,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [tea_pkg::ADDR_W-1:0]   paddr,
  input  logic [tea_pkg::DATA_W-1:0]   pwdata,
  output logic [tea_pkg::DATA_W-1:0]   prdata,
  output logic                         pready
);
  import tea_pkg::*;

  logic [CNT_W-1:0] tri_count_r;
  logic             reg_sel;
  tea_cmd_t         cmd;
  tea_stat_t        stat;

  // register file
  assign pready  = 1'b1;
  assign reg_sel = paddr[ADDR_W-1:2] == REG_TRI_COUNT;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tri_count_r <= '0;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      tri_count_r <= pwdata[CNT_W-1:0];
    end
  end

  assign prdata = reg_sel ? DATA_W'(tri_count_r) : '0;

  // controller
  tea_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_op    (in_op),
    .stat     (stat),
    .in_stall (in_stall),
    .cmd      (cmd)
  );

  // datapath
  tea_dp #(
    .MAX_TRIS       (MAX_TRIS),
    .MAX_NEIGHBOURS (MAX_NEIGHBOURS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .stat             (stat),
    .tri_count        (tri_count_r),
    .in_tri_id        (in_tri_id),
    .in_vert_a        (in_vert_a),
    .in_vert_b        (in_vert_b),
    .in_vert_c        (in_vert_c),
    .out_stall        (out_stall),
    .out_valid        (out_valid),
    .out_neighbour_id (out_neighbour_id),
    .out_edge_slot    (out_edge_slot),
    .out_found        (out_found),
    .out_overflow     (out_overflow),
    .out_last         (out_last)
  );

  // an empty result closes its query
  a_nomatch_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_found |-> out_last)
    else $error("no-match result without last");

  // overflow only on a final result that carries a neighbour
  a_over_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_overflow |-> out_last && out_found)
    else $error("overflow on a non-final or empty result");

  // an accepted query holds off the input on the next cycle
  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_op == OP_QUERY |=> in_stall)
    else $error("input taken while a query is in progress");

endmodule
